/* rtl/acmac_pkg.sv */
// ----------------------------------------------------------------------------
// acmac_pkg: shared types, constants and functions of the AES-CMAC engine
// Holds the S-box, the round helpers and the controller/datapath command and
// status structures.
// ----------------------------------------------------------------------------
package acmac_pkg;

  localparam logic [7:0] CmacRb  = 8'h87;
  localparam logic [7:0] CmacPad = 8'h80;

  localparam logic [2:0] CfgKey0 = 3'd0;
  localparam logic [2:0] CfgKey1 = 3'd1;
  localparam logic [2:0] CfgKey2 = 3'd2;
  localparam logic [2:0] CfgKey3 = 3'd3;
  localparam logic [2:0] CfgMode = 3'd4;

  typedef enum logic [2:0] {
    StIdle,
    StDerive,
    StDeriveRun,
    StBlockRun,
    StOutput
  } acmac_state_e;

  // Command word from controller to datapath.
  typedef struct packed {
    logic start_derive;  // load zero block and initial round key
    logic start_block;   // load chain xor message and initial round key
    logic round;         // perform one round and advance key schedule
    logic finish_derive; // store subkeys from final state
    logic finish_block;  // store chain value, or tag and clear chain
    logic take_input;    // latch the input item
  } acmac_cmd_t;

  typedef struct packed {
    logic last_round;    // the round about to run is the final one
    logic short_block;   // latched item is short and not last
    logic msg_end;       // latched item is last
  } acmac_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word, byte 0 in the top bits.
  function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
    return w[127-8*i -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // SubBytes, ShiftRows and, unless final, MixColumns.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) t[i] = SBOX[get_byte(s, i)];
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++) u[j + 4*c] = t[j + 4*((c + j) % 4)];
    for (int c = 0; c < 4; c++) begin
      a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
      x = a0 ^ a1 ^ a2 ^ a3;
      if (!final_rnd) begin
        u[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        u[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        u[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        u[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = u[i];
    return r;
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? CmacRb : 8'h00)};
  endfunction

endpackage

/* rtl/aes_cmac_engine_unit.sv */
// ----------------------------------------------------------------------------
// aes_cmac_engine_unit: AES-CMAC tag engine, AES-128 or AES-256
// Top level joining controller, datapath and output register.
// ----------------------------------------------------------------------------
// Usage: write the key words and the key length through the configuration
// channel while the engine is idle; each write to a key word or to the key
// length forces a fresh subkey derivation before the next block. Message
// blocks arrive on the slave stream, one 16-byte block per transfer, with its
// byte count in tuser and the last mark on tlast. A full non-last block only
// updates the chain; a last block produces one tag transfer; a short non-last
// block produces one transfer with the error flag set and a zero tag.
// Sequence: a full non-last block is loaded and then runs 10 or 14 rounds
// on the single iterative round unit, and the next block is taken in the
// cycle after its last round. A last block then loads the output register
// with its tag before the next block is taken. A short non-last block skips
// the rounds and goes straight to the output register. A block that finds
// the subkeys stale first encrypts the zero block on the same round unit.
// The round unit is the limit.
// Reset clears the key, chain and subkey-ready flag and empties the output.
// When the receiver stalls, the result waits in the output register and the
// engine finishes the next block, holding off only while that register is full.
// ----------------------------------------------------------------------------
module aes_cmac_engine_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // block_high [63:0], block_low [127:64]
  input  logic [4:0]   s_axis_tuser,   // byte_count [4:0]
  input  logic         s_axis_tlast,   // last mark of the message
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // tag_high [63:0], tag_low [127:64]
  output logic         m_axis_tuser    // error
);
  import acmac_pkg::*;

  acmac_cmd_t    cmd;
  acmac_status_t status;
  logic          keys_ready, out_load;
  logic [127:0]  tag;
  logic          out_valid_q;
  logic [127:0]  out_data_q;
  logic          out_err_q;

  assign cfg_ready_o = 1'b1;

  acmac_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .out_free_i   (!out_valid_q || m_axis_tready),
    .out_load_o   (out_load),
    .keys_ready_i (keys_ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  acmac_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i     (cfg_valid_i),
    .cfg_idx_i    (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_block_i   ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .in_count_i   (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .cmd_i        (cmd),
    .status_o     (status),
    .keys_ready_o (keys_ready),
    .tag_o        (tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end

  // Internally the tag is big-endian with tag_high on top.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {tag[63:0], tag[127:64]};
      out_err_q <= status.short_block;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_err_q;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start_derive, cmd.start_block, cmd.round, cmd.take_input}))
    else $error("conflicting datapath commands");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_block_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_block |-> keys_ready)
    else $error("block started with stale subkeys");
endmodule

/* rtl/acmac_ctrl.sv */
// ----------------------------------------------------------------------------
// acmac_ctrl: sequencing state machine of the AES-CMAC engine
// Derives subkeys when needed, runs the rounds of each block and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module acmac_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    out_free_i,
  output logic                    out_load_o,
  input  logic                    keys_ready_i,
  input  acmac_pkg::acmac_status_t status_i,
  output acmac_pkg::acmac_cmd_t    cmd_o
);
  import acmac_pkg::*;

  acmac_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:      if (in_valid_i) state_d = StDerive;
      StDerive: begin
        if (!keys_ready_i) state_d = StDeriveRun;
        else if (status_i.short_block) state_d = StOutput;
        else state_d = StBlockRun;
      end
      StDeriveRun: if (status_i.last_round) state_d = StDerive;
      StBlockRun: begin
        if (status_i.last_round) state_d = status_i.msg_end ? StOutput : StIdle;
      end
      StOutput:    if (out_free_i) state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.take_input = in_valid_i;
      end
      StDerive: begin
        cmd_o.start_derive = !keys_ready_i;
        cmd_o.start_block = keys_ready_i && !status_i.short_block;
      end
      StDeriveRun: begin
        cmd_o.round = 1'b1;
        cmd_o.finish_derive = status_i.last_round;
      end
      StBlockRun: begin
        cmd_o.round = 1'b1;
        cmd_o.finish_block = status_i.last_round;
      end
      StOutput: out_load_o = out_free_i;
      default: ;
    endcase
  end
endmodule

/* rtl/acmac_dp.sv */
// ----------------------------------------------------------------------------
// acmac_dp: datapath of the AES-CMAC engine
// Key registers, iterative AES round unit with on-the-fly key expansion,
// chain value, subkeys and block formatting.
// ----------------------------------------------------------------------------
module acmac_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [63:0]              cfg_data_i,
  input  logic [127:0]             in_block_i,
  input  logic [4:0]               in_count_i,
  input  logic                     in_last_i,
  input  acmac_pkg::acmac_cmd_t     cmd_i,
  output acmac_pkg::acmac_status_t  status_o,
  output logic                     keys_ready_o,
  output logic [127:0]             tag_o
);
  import acmac_pkg::*;

  logic [63:0]  key_q [4];
  logic         mode_q;
  logic         keys_ready_q;
  logic [127:0] chain_q, k1_q, k2_q, state_q, tag_q;
  logic [255:0] win_q;     // two most recent round keys, older in top half
  logic [3:0]   rnd_q;     // round about to run, 1..14
  logic [7:0]   rc_q;
  logic [127:0] blk_q;
  logic [4:0]   cnt_q;
  logic         last_q;

  logic [3:0]   nr;
  logic [127:0] rk_cur, rk_next, msg, padded, rnd_out;
  logic [255:0] key_full;
  logic [31:0]  w0, w1, w2, w3, tmp;
  logic [4:0]   n_sat;

  assign nr = mode_q ? 4'd14 : 4'd10;
  assign key_full = {key_q[0], key_q[1], key_q[2], key_q[3]};

  // Next round key: AES-128 uses one word group, AES-256 alternates halves.
  always_comb begin
    logic [127:0] base, prev;
    base = mode_q ? win_q[255:128] : win_q[127:0];
    prev = win_q[127:0];
    if (!mode_q || rnd_q[0] == 1'b0)
      tmp = sub_word({prev[23:0], prev[31:24]}) ^ {rc_q, 24'd0};
    else
      tmp = sub_word(prev[31:0]);
    w0 = base[127:96] ^ tmp;
    w1 = base[95:64] ^ w0;
    w2 = base[63:32] ^ w1;
    w3 = base[31:0] ^ w2;
    rk_next = {w0, w1, w2, w3};
  end

  // In AES-256 round 1 uses the second key half (key words 2 and 3), already in the window.
  assign rk_cur = (mode_q && rnd_q == 4'd1) ? win_q[127:0] : rk_next;
  assign rnd_out = aes_round(state_q, rnd_q == nr) ^ rk_cur;

  assign n_sat = (cnt_q > 5'd16) ? 5'd16 : cnt_q;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < n_sat) padded[127-8*i -: 8] = get_byte(blk_q, i);
      else if (5'(i) == n_sat) padded[127-8*i -: 8] = CmacPad;
      else padded[127-8*i -: 8] = 8'h00;
    end
    if (!last_q) msg = blk_q;
    else if (n_sat == 5'd16) msg = blk_q ^ k1_q;
    else msg = padded ^ k2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      mode_q <= 1'b0;
      keys_ready_q <= 1'b0;
      chain_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgKey0 || cfg_idx_i == CfgKey1 ||
            cfg_idx_i == CfgKey2 || cfg_idx_i == CfgKey3) begin
          key_q[cfg_idx_i[1:0]] <= cfg_data_i;
          keys_ready_q <= 1'b0;
        end else if (cfg_idx_i == CfgMode) begin
          mode_q <= cfg_data_i[0];
          keys_ready_q <= 1'b0;
        end
      end
      if (cmd_i.finish_derive) keys_ready_q <= 1'b1;
      if (cmd_i.finish_block) chain_q <= last_q ? '0 : rnd_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_input) begin
      blk_q <= in_block_i;
      cnt_q <= in_count_i;
      last_q <= in_last_i;
    end
    if (cmd_i.start_derive || cmd_i.start_block) begin
      state_q <= (cmd_i.start_block ? (chain_q ^ msg) : 128'd0) ^ key_full[255:128];
      win_q <= mode_q ? key_full : {128'd0, key_full[255:128]};
      rnd_q <= 4'd1;
      rc_q <= 8'h01;
    end else if (cmd_i.round) begin
      state_q <= rnd_out;
      rnd_q <= rnd_q + 4'd1;
      if (!(mode_q && rnd_q == 4'd1)) begin
        win_q <= {win_q[127:0], rk_next};
        if (!mode_q || rnd_q[0] == 1'b0) rc_q <= xtime(rc_q);
      end
    end
    if (cmd_i.finish_derive) begin
      k1_q <= dbl(rnd_out);
      k2_q <= dbl(dbl(rnd_out));
    end
    if (cmd_i.finish_block) tag_q <= rnd_out;
  end

  assign status_o.last_round = (rnd_q == nr);
  assign status_o.short_block = !last_q && (cnt_q < 5'd16);
  assign status_o.msg_end = last_q;
  assign keys_ready_o = keys_ready_q;
  assign tag_o = status_o.short_block ? 128'd0 : tag_q;
endmodule

/* sim/aes_cmac_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_cmac_engine_checker: tag predictor and scoreboard for the CMAC engine
// Watches the configuration, block and tag channels. It keeps its own key,
// chain and subkeys, computes each expected tag with its own AES, and
// compares every tag transfer with the oldest expectation.
// ----------------------------------------------------------------------------
module aes_cmac_engine_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [127:0] s_tdata_i,
  input  logic [4:0]   s_tuser_i,
  input  logic         s_tlast_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [127:0] m_tdata_i,
  input  logic         m_tuser_i,
  output int           fail_count_o,
  output int           tags_pending_o
);
  import acmac_pkg::*;

  typedef struct {
    logic [127:0] tag;
    logic         err;
  } tag_result_t;

  tag_result_t tags_due[$];

  logic [7:0]   sub_tab [256];
  logic [63:0]  key_reg [4];
  logic         aes256;
  logic [127:0] chain, k_one, k_two;
  logic         keys_fresh;

  function automatic logic [7:0] mul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = mul2(a);
      b = b >> 1;
    end
    return p;
  endfunction

  // The substitution table is built from the field inverse and the affine map.
  initial begin
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      b = inv;
      for (int k = 0; k < 4; k++) begin
        b = {b[6:0], b[7]};
        inv ^= b;
      end
      sub_tab[x] = inv ^ 8'h63;
    end
  end

  function automatic logic [127:0] encrypt(input logic [127:0] din);
    logic [7:0] rk [240];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] w0, rc, a0, a1, a2, a3, x;
    logic [127:0] dout;
    int nk, nr;
    nk = aes256 ? 8 : 4;
    nr = aes256 ? 14 : 10;
    rc = 8'h01;
    for (int i = 0; i < 4 * nk; i++)
      rk[i] = key_reg[i / 8][63 - 8 * (i % 8) -: 8];
    for (int i = 4 * nk; i < 16 * (nr + 1); i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
      if ((i / 4) % nk == 0) begin
        w0 = w[0];
        w[0] = sub_tab[w[1]] ^ rc;
        w[1] = sub_tab[w[2]];
        w[2] = sub_tab[w[3]];
        w[3] = sub_tab[w0];
        rc = mul2(rc);
      end else if (nk == 8 && (i / 4) % nk == 4) begin
        for (int j = 0; j < 4; j++) w[j] = sub_tab[w[j]];
      end
      for (int j = 0; j < 4; j++) rk[i + j] = rk[i + j - 4 * nk] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = din[127 - 8 * i -: 8] ^ rk[i];
    for (int r = 1; r <= nr; r++) begin
      for (int i = 0; i < 16; i++) t[i] = sub_tab[s[i]];
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) s[j + 4 * c] = t[j + 4 * ((c + j) % 4)];
      if (r < nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
          x = a0 ^ a1 ^ a2 ^ a3;
          s[4 * c]     = a0 ^ x ^ mul2(a0 ^ a1);
          s[4 * c + 1] = a1 ^ x ^ mul2(a1 ^ a2);
          s[4 * c + 2] = a2 ^ x ^ mul2(a2 ^ a3);
          s[4 * c + 3] = a3 ^ x ^ mul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[16 * r + i];
    end
    for (int i = 0; i < 16; i++) dout[127 - 8 * i -: 8] = s[i];
    return dout;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? 8'h87 : 8'h00)};
  endfunction

  // One accepted block: returns 1 when it yields a tag transfer.
  function automatic bit absorb_block(input logic [63:0] hi, input logic [63:0] lo,
                                      input logic [4:0] cnt, input logic last,
                                      output tag_result_t res);
    logic [127:0] blk;
    int n;
    n = (cnt > 16) ? 16 : int'(cnt);
    if (!keys_fresh) begin
      k_one = gf_double(encrypt(128'd0));
      k_two = gf_double(k_one);
      keys_fresh = 1'b1;
    end
    if (!last && n < 16) begin
      res.tag = '0;
      res.err = 1'b1;
      return 1'b1;
    end
    blk = {hi, lo};
    if (last) begin
      if (n == 16) begin
        blk ^= k_one;
      end else begin
        for (int i = n; i < 16; i++) blk[127 - 8 * i -: 8] = (i == n) ? 8'h80 : 8'h00;
        blk ^= k_two;
      end
    end
    chain = encrypt(chain ^ blk);
    if (!last) return 1'b0;
    res.tag = chain;
    res.err = 1'b0;
    chain = '0;
    return 1'b1;
  endfunction

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    tags_pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    tag_result_t res;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      aes256 = 1'b0;
      chain = '0;
      keys_fresh = 1'b0;
      tags_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i <= CfgKey3) begin
          key_reg[cfg_index_i[1:0]] = cfg_data_i;
          keys_fresh = 1'b0;
        end else if (cfg_index_i == CfgMode) begin
          aes256 = cfg_data_i[0];
          keys_fresh = 1'b0;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (absorb_block(s_tdata_i[63:0], s_tdata_i[127:64], s_tuser_i, s_tlast_i, res))
          tags_due.push_back(res);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (tags_due.size() == 0) begin
          report("unexpected tag transfer", 64'd0, m_tdata_i[63:0]);
        end else begin
          res = tags_due.pop_front();
          if (m_tdata_i[63:0] !== res.tag[127:64])
            report("tag_high", res.tag[127:64], m_tdata_i[63:0]);
          if (m_tdata_i[127:64] !== res.tag[63:0])
            report("tag_low", res.tag[63:0], m_tdata_i[127:64]);
          if (m_tuser_i !== res.err)
            report("error flag", 64'(res.err), 64'(m_tuser_i));
        end
      end
    end
    tags_pending_o = tags_due.size();
  end

endmodule

/* sim/tb_aes_cmac_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes_cmac_engine_unit: stimulus and verdict for the AES-CMAC engine
// Writes keys and key lengths between phases, sends directed and random
// messages with random gaps on both streams, and leaves all checking to the
// checker instantiated beside the engine.
// ----------------------------------------------------------------------------
module tb_aes_cmac_engine_unit;
  import acmac_pkg::*;

  // Cycles without any transfer before the run is declared hung. The worst
  // honest case is a long receiver hold-off plus a derivation and a block.
  localparam int QuietLimit = 4000;
  // Settling time after the last tag: a derivation and an AES-256 block.
  localparam int SettleCycles = 40;
  localparam int HoldCycles = 300;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;    // block_high [63:0], block_low [127:64]
  logic [4:0]   s_tuser = '0;    // byte_count [4:0]
  logic         s_tlast = 1'b0;  // last mark of the message
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;         // tag_high [63:0], tag_low [127:64]
  logic         m_tuser;         // error
  int           fail_count;
  int           tags_pending;
  int           blocks_sent = 0;
  int           quiet = 0;
  bit           no_gaps = 1'b0;
  bit           hold_rx = 1'b0;

  always #4 clk_i = ~clk_i;

  aes_cmac_engine_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  aes_cmac_engine_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .s_tuser_i      (s_tuser),
    .s_tlast_i      (s_tlast),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .m_tuser_i      (m_tuser),
    .fail_count_o   (fail_count),
    .tags_pending_o (tags_pending)
  );

  // The watchdog restarts on every transfer on any of the three channels.
  always @(posedge clk_i) begin
    if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("FAIL aes_cmac_engine_unit");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Tag receiver. Mostly ready, sometimes stalling for a few cycles, and on
  // request it holds off for a long stretch so that the engine backs up.
  initial begin
    int r;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx = 1'b0;
      end else begin
        r = $urandom_range(99);
        if (no_gaps)     m_tready <= 1'b1;
        else if (r < 3)  m_tready <= 1'b0;  // start of a longer stall, below
        else             m_tready <= (r < 75);
        if (!no_gaps && r < 3) repeat ($urandom_range(30, 8)) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [63:0] pick_word();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // One block transfer; valid stays high straight into the next block when
  // no gap is drawn.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic [4:0] cnt, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {lo, hi};
    s_tuser <= cnt;
    s_tlast <= last;
    do @(posedge clk_i); while (!s_tready);
    blocks_sent++;
  endtask

  // Waits until every expected tag has arrived, then lets a possible
  // trailing chain-only block finish before the engine is touched.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tags_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_setup();
    for (int i = 0; i < 5; i++)
      if ($urandom_range(1)) cfg_write(3'(i), pick_word());
    if ($urandom_range(3) == 0) cfg_write(3'($urandom_range(7, 5)), pick_word());
  endtask

  task automatic send_message();
    int nblk, r;
    logic [4:0] cnt;
    nblk = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
    for (int b = 0; b < nblk - 1; b++) begin
      r = $urandom_range(99);
      if (r < 5)       cnt = 5'($urandom_range(15));       // short, flagged as error
      else if (r < 9)  cnt = 5'($urandom_range(31, 17));   // saturates to full
      else             cnt = 5'd16;
      send_block(pick_word(), pick_word(), cnt, 1'b0);
      // Now and then the key changes while a message is under way.
      if ($urandom_range(99) < 2) begin
        drain();
        random_setup();
      end
    end
    r = $urandom_range(99);
    if (r < 40)      cnt = 5'd16;
    else if (r < 50) cnt = 5'($urandom_range(31, 17));
    else             cnt = 5'($urandom_range(15));
    send_block(pick_word(), pick_word(), cnt, 1'b1);
  endtask

  initial begin
    int target;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first under the reset key (all zero, AES-128).
    send_block('0, '0, 5'd0, 1'b1);         // empty message
    send_block('1, '1, 5'd16, 1'b1);        // one full block
    drain();
    cfg_write(CfgKey0, 64'h2b7e151628aed2a6);
    cfg_write(CfgKey1, 64'habf7158809cf4f3c);
    cfg_write(CfgKey2, '1);
    cfg_write(CfgKey3, '0);
    cfg_write(CfgMode, 64'd0);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
    send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd16, 1'b0);
    send_block(64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef, 5'd1, 1'b1);
    send_block('1, '1, 5'd15, 1'b1);
    send_block('1, '1, 5'd0, 1'b0);         // short non-last block
    send_block('1, '0, 5'd15, 1'b0);
    send_block('0, '1, 5'd31, 1'b0);        // oversized count, full block
    send_block('1, '1, 5'd17, 1'b1);
    drain();
    cfg_write(3'd5, '1);                    // indexes past the mode register
    cfg_write(3'd6, '1);
    cfg_write(3'd7, '0);
    cfg_write(CfgMode, '1);                 // only bit 0 counts: AES-256
    send_block('0, '0, 5'd0, 1'b1);
    send_block('1, '1, 5'd16, 1'b0);
    send_block(64'h0123456789abcdef, '1, 5'd8, 1'b1);
    send_block('1, '1, 5'd24, 1'b1);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          for (int i = 0; i < 4; i++) cfg_write(3'(i), '1);
          cfg_write(CfgMode, 64'd1);
        end
        1: begin
          for (int i = 0; i < 4; i++) cfg_write(3'(i), '0);
          cfg_write(CfgMode, 64'hfffffffffffffffe);
        end
        default: random_setup();
      endcase
      no_gaps = (phase == 3 || phase == 7);
      if (phase == 5) begin
        // Long receiver hold-off while single-block messages keep coming.
        hold_rx = 1'b1;
        for (int k = 0; k < 20; k++) send_block(pick_word(), pick_word(), 5'd16, 1'b1);
      end
      target = blocks_sent + 183;
      while (blocks_sent < target) send_message();
      drain();
    end

    no_gaps = 1'b0;
    if (fail_count == 0) begin
      $display("PASS aes_cmac_engine_unit");
    end else begin
      $display("FAIL aes_cmac_engine_unit");
    end
    $finish;
  end

endmodule

/* aes_cmac_engine_unit.f */
rtl/acmac_pkg.sv
rtl/acmac_ctrl.sv
rtl/acmac_dp.sv
rtl/aes_cmac_engine_unit.sv
sim/aes_cmac_engine_checker.sv
sim/tb_aes_cmac_engine_unit.sv
